// ----- hw/rtl/svpa_pkg.sv -----
// Shared constants for the sample voice position advance block.
// Fixed-point widths, loop mode codes and register indexes.
// No dependencies.
package svpa_pkg;

   // fraction bits of the position and of the pitch step (8..32)
   localparam int FRAC_BITS  = 32;
   // low bits of the sample count used by an advance (8..16)
   localparam int COUNT_BITS = 16;

   // integer part (32) plus fraction: width of the step product and of the shared adder
   localparam int ACC_W      = 32 + FRAC_BITS;

   // pitch step field width, 16.32 format
   localparam int STEP_W     = 48;

   // loop modes
   localparam logic [1:0] MODE_NONE      = 2'd0;
   localparam logic [1:0] MODE_FORWARD   = 2'd1;
   localparam logic [1:0] MODE_PING_PONG = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_LOOP_MODE  = 2'd0;
   localparam logic [1:0] CSR_LOOP_BEGIN = 2'd1;
   localparam logic [1:0] CSR_LOOP_END   = 2'd2;
   localparam logic [1:0] CSR_DISOWNED   = 2'd3;

   // request types
   localparam logic REQ_ADVANCE = 1'b0;
   localparam logic REQ_START   = 1'b1;

endpackage

// ----- hw/rtl/sample_voice_position_advance_hq.sv -----
// Top level of the sample voice position advance block (high precision).
// Sequencer around one shared adder/subtractor: multiply, carry add, modulo.
// Depends on svpa_pkg.

// One voice, one transaction at a time. A start request answers in the cycle after
// it is taken. An advance runs a shift-add multiply of pitch step by sample count, one
// count bit per cycle and ending early once the remaining count bits are zero, then
// one carry add, one end check, and it answers there unless a non-empty loop wraps.
// A loop wrap or reflection adds the distance step ST_DVD, a 32-step restoring
// modulo and the fix-up steps ST_FIX1 (ping-pong only) and ST_FIX2. Every arithmetic
// step goes through the same adder. req_ready is high only while idle; the next
// request is taken in the cycle after the result transaction completes. Configuration
// writes land at once and are expected only while idle.
module sample_voice_position_advance_hq (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [47:0] req_pitch_step,
   input  logic [15:0] req_num_samples,
   input  logic [30:0] req_start_position,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_position,
   output logic [31:0] rsp_fraction,
   output logic        rsp_going_backwards,
   output logic        rsp_note_stopped,
   output logic        rsp_channel_off,
   output logic        rsp_looped,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   localparam int FracW  = svpa_pkg::FRAC_BITS;
   localparam int CountW = svpa_pkg::COUNT_BITS;
   localparam int AccW   = svpa_pkg::ACC_W;
   localparam int DivSteps = 32;
   localparam int DivCntW  = $clog2(DivSteps);
   localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;  // wait for a request
   localparam logic [3:0] ST_MUL  = 4'd1;  // shift-add step * count
   localparam logic [3:0] ST_ADD  = 4'd2;  // position +/- product
   localparam logic [3:0] ST_LEN  = 4'd3;  // loop length, end check
   localparam logic [3:0] ST_DVD  = 4'd4;  // distance past the edge
   localparam logic [3:0] ST_DIV  = 4'd5;  // restoring modulo, one bit a cycle
   localparam logic [3:0] ST_FIX1 = 4'd6;  // remainder minus loop length
   localparam logic [3:0] ST_FIX2 = 4'd7;  // final position, direction
   localparam logic [3:0] ST_OUT  = 4'd8;  // result held for the response

   logic [3:0]        state_ff, state_in;

   // configuration
   logic [1:0]        loop_mode_ff;
   logic [30:0]       loop_begin_ff, loop_end_ff;
   logic              disowned_ff;

   // voice state
   logic [31:0]       pos_ff, pos_in;
   logic [FracW-1:0]  frac_ff, frac_in;
   logic              dir_ff, dir_in;
   logic              stopped_ff, stopped_in;
   logic              chan_off_ff, chan_off_in;
   logic              looped_ff, looped_in;

   // working registers
   logic [AccW-1:0]   acc_ff, acc_in;
   logic [AccW-1:0]   mcand_ff, mcand_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [31:0]       p_ff, p_in;
   logic [31:0]       len_ff, len_in;
   logic [31:0]       divisor_ff, divisor_in;
   logic [31:0]       dvd_ff, dvd_in;
   logic [31:0]       rem_ff, rem_in;
   logic [DivCntW-1:0] div_cnt_ff, div_cnt_in;
   logic [31:0]       t_ff, t_in;
   logic              ge_ff, ge_in;

   // shared adder
   logic [AccW-1:0]   alu_a, alu_b, alu_sum;
   logic              alu_sub;

   logic              backward;
   logic              hit;
   logic              zero_len;
   logic [32:0]       rem_shift;
   logic [31:0]       begin_ext, end_ext;

   assign begin_ext = {1'b0, loop_begin_ff};
   assign end_ext   = {1'b0, loop_end_ff};
   assign backward  = (loop_mode_ff == svpa_pkg::MODE_PING_PONG) && dir_ff;
   assign rem_shift = {rem_ff, dvd_ff[31]};
   assign zero_len  = (loop_begin_ff == loop_end_ff);

   // backward edge: signed compare; forward end: unsigned
   assign hit = backward ? ($signed(p_ff) <= $signed(begin_ext)) : (p_ff >= end_ext);

   // operand selection for the shared adder
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = mcand_ff;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_ADD: begin
            alu_a   = {pos_ff, frac_ff};
            alu_b   = acc_ff;
            alu_sub = backward;
         end
         ST_LEN: begin
            alu_a   = AccW'(end_ext);
            alu_b   = AccW'(begin_ext);
            alu_sub = 1'b1;
         end
         ST_DVD: begin
            alu_a   = backward ? AccW'(begin_ext) : AccW'(p_ff);
            alu_b   = backward ? AccW'(p_ff) : AccW'(end_ext);
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_a   = AccW'(rem_shift);
            alu_b   = AccW'(divisor_ff);
            alu_sub = 1'b1;
         end
         ST_FIX1: begin
            alu_a   = AccW'(rem_ff);
            alu_b   = AccW'(len_ff);
            alu_sub = 1'b1;
         end
         ST_FIX2: begin
            // end + ~x is (end - 1) - x
            if (loop_mode_ff != svpa_pkg::MODE_PING_PONG) begin
               alu_a = AccW'(begin_ext);
               alu_b = AccW'(rem_ff);
            end else if (!backward) begin
               alu_a = ge_ff ? AccW'(begin_ext) : AccW'(end_ext);
               alu_b = ge_ff ? AccW'(t_ff) : AccW'(~rem_ff);
            end else begin
               alu_a = ge_ff ? AccW'(end_ext) : AccW'(begin_ext);
               alu_b = ge_ff ? AccW'(~t_ff) : AccW'(rem_ff);
            end
         end
         default: begin
            alu_a   = acc_ff;
            alu_b   = mcand_ff;
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AccW'(alu_sub);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      frac_in     = frac_ff;
      dir_in      = dir_ff;
      stopped_in  = stopped_ff;
      chan_off_in = chan_off_ff;
      looped_in   = looped_ff;
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      cnt_in      = cnt_ff;
      p_in        = p_ff;
      len_in      = len_ff;
      divisor_in  = divisor_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      t_in        = t_ff;
      ge_in       = ge_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == svpa_pkg::REQ_START) begin
                  pos_in      = {1'b0, req_start_position};
                  frac_in     = '0;
                  dir_in      = 1'b0;
                  stopped_in  = 1'b0;
                  chan_off_in = 1'b0;
                  looped_in   = 1'b0;
                  state_in    = ST_OUT;
               end else begin
                  acc_in   = '0;
                  mcand_in = AccW'(req_pitch_step);
                  cnt_in   = req_num_samples[CountW-1:0];
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = ST_ADD;
            end else begin
               if (cnt_ff[0]) begin
                  acc_in = alu_sum;
               end
               mcand_in = mcand_ff << 1;
               cnt_in   = cnt_ff >> 1;
            end
         end
         ST_ADD: begin
            p_in     = alu_sum[AccW-1 -: 32];
            frac_in  = alu_sum[FracW-1:0];
            state_in = ST_LEN;
         end
         ST_LEN: begin
            len_in   = alu_sum[31:0];
            state_in = ST_OUT;
            case (loop_mode_ff)
               svpa_pkg::MODE_FORWARD: begin
                  if (!hit) begin
                     pos_in = p_ff;
                  end else if (zero_len) begin
                     pos_in    = '0;
                     looped_in = 1'b1;
                  end else begin
                     divisor_in = alu_sum[31:0];
                     state_in   = ST_DVD;
                  end
               end
               svpa_pkg::MODE_PING_PONG: begin
                  if (!hit) begin
                     pos_in = p_ff;
                  end else if (zero_len) begin
                     pos_in    = begin_ext;
                     looped_in = 1'b1;
                  end else begin
                     divisor_in = {alu_sum[30:0], 1'b0};
                     state_in   = ST_DVD;
                  end
               end
               default: begin
                  // no loop: stop at the end; the owned channel keeps its position
                  if (hit) begin
                     stopped_in = 1'b1;
                  end
                  if (hit && !disowned_ff) begin
                     chan_off_in = 1'b1;
                  end else begin
                     pos_in = p_ff;
                  end
               end
            endcase
         end
         ST_DVD: begin
            dvd_in     = alu_sum[31:0];
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // trial subtract; keep it when it does not go negative
            rem_in     = alu_sum[AccW-1] ? rem_shift[31:0] : alu_sum[31:0];
            dvd_in     = dvd_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DivLast) begin
               state_in = (loop_mode_ff == svpa_pkg::MODE_PING_PONG) ? ST_FIX1 : ST_FIX2;
            end
         end
         ST_FIX1: begin
            t_in     = alu_sum[31:0];
            ge_in    = !alu_sum[AccW-1];
            state_in = ST_FIX2;
         end
         ST_FIX2: begin
            pos_in    = alu_sum[31:0];
            looped_in = 1'b1;
            if (loop_mode_ff == svpa_pkg::MODE_PING_PONG) begin
               if (!backward) begin
                  // upper reflection turns back if !ge_ff unless it is the loop start
                  if (!ge_ff && (alu_sum[31:0] != begin_ext)) begin
                     dir_in  = 1'b1;
                     frac_in = -frac_ff;
                  end
               end else if (!ge_ff || (alu_sum[31:0] == begin_ext)) begin
                  dir_in  = 1'b0;
                  frac_in = -frac_ff;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control, configuration and voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         loop_mode_ff  <= svpa_pkg::MODE_NONE;
         loop_begin_ff <= '0;
         loop_end_ff   <= '0;
         disowned_ff   <= 1'b0;
         pos_ff        <= '0;
         frac_ff       <= '0;
         dir_ff        <= 1'b0;
         stopped_ff    <= 1'b0;
         chan_off_ff   <= 1'b0;
         looped_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         frac_ff     <= frac_in;
         dir_ff      <= dir_in;
         stopped_ff  <= stopped_in;
         chan_off_ff <= chan_off_in;
         looped_ff   <= looped_in;
         if (csr_we) begin
            unique case (csr_index)
               svpa_pkg::CSR_LOOP_MODE:  loop_mode_ff  <= csr_wdata[1:0];
               svpa_pkg::CSR_LOOP_BEGIN: loop_begin_ff <= csr_wdata;
               svpa_pkg::CSR_LOOP_END:   loop_end_ff   <= csr_wdata;
               svpa_pkg::CSR_DISOWNED:   disowned_ff   <= csr_wdata[0];
               default:                  disowned_ff   <= disowned_ff;
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      cnt_ff     <= cnt_in;
      p_ff       <= p_in;
      len_ff     <= len_in;
      divisor_ff <= divisor_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      t_ff       <= t_in;
      ge_ff      <= ge_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_position        = $signed(pos_ff);
   assign rsp_fraction        = 32'(frac_ff);
   assign rsp_going_backwards = dir_ff;
   assign rsp_note_stopped    = stopped_ff;
   assign rsp_channel_off     = chan_off_ff;
   assign rsp_looped          = looped_ff;

endmodule

// ----- hw/rtl/svpa_checker.sv -----
// Port-level checks for sample_voice_position_advance_hq.
// Holds the checker module and its bind; needs no package.
module svpa_port_checks (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic [30:0] req_start_position,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic signed [31:0] rsp_position,
   input  logic [31:0] rsp_fraction,
   input  logic        rsp_going_backwards,
   input  logic        rsp_note_stopped,
   input  logic        rsp_channel_off,
   input  logic        rsp_looped
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) && $stable(rsp_fraction))
      else $error("response changed while stalled");

   // no request is taken while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a response is pending");

   // one response per transaction
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response repeated");

   // a start request answers next cycle with a clean voice
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type |=> rsp_valid && rsp_fraction == 32'd0
         && !rsp_going_backwards && !rsp_note_stopped && !rsp_channel_off && !rsp_looped
         && rsp_position == $signed({1'b0, $past(req_start_position)}))
      else $error("start request result wrong");

endmodule

bind sample_voice_position_advance_hq svpa_port_checks u_svpa_port_checks (.*);
